// ----- rtl/i2c_master_register_transfer_top_assert.svh -----
// Assertion macros for the I2C register transfer master checker.
// Depends on nothing; included by the checker file only.
`ifndef I2C_MASTER_REGISTER_TRANSFER_TOP_ASSERT_SVH
`define I2C_MASTER_REGISTER_TRANSFER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define I2CM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2cm check failed");

// Next-cycle implication, disabled while reset is asserted
`define I2CM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2cm check failed");

`endif

// ----- rtl/i2cm_pkg.sv -----
// Shared types and constants for the I2C register transfer master.
// No dependencies; imported by every module of the block.
package i2cm_pkg;

    // Write buffer depth and derived widths
    localparam int MaxBytes = 16;
    localparam int PtrW     = $clog2(MaxBytes);
    localparam int LpW      = PtrW + 1;
    localparam int IdxW     = 5;

    // Queue between front and back (power of two depth)
    localparam int QDepth = 2;
    localparam int QPtrW  = $clog2(QDepth);

    // Opcodes of the input beat
    localparam logic [1:0] OpTick   = 2'd0;
    localparam logic [1:0] OpLaunch = 2'd1;
    localparam logic [1:0] OpLoad   = 2'd2;

    localparam logic [1:0]  SubLenTwo     = 2'd2;
    localparam logic [4:0]  CountMax      = 5'(MaxBytes);
    localparam logic [15:0] PhaseTicksRst = 16'd2;
    localparam logic        AddrReadBit   = 1'b1;

    typedef struct packed {
        logic [1:0]  opcode;
        logic        sda_in;
        logic [6:0]  target_addr;
        logic [15:0] reg_addr;
        logic [1:0]  reg_addr_len;
        logic        is_read;
        logic [4:0]  byte_count;
        logic [7:0]  data_byte;
    } t_in_item;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       read_valid;
        logic [7:0] read_data;
        logic       done_res;
        logic       status;
    } t_out_item;

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_LAUNCH,
        CMD_LOAD
    } t_cmd_kind;

    // Classified command held in the queue
    typedef struct packed {
        t_cmd_kind   kind;
        logic        sda;
        logic [6:0]  addr;
        logic [15:0] reg_addr;
        logic        two_byte;
        logic        is_read;
        logic [4:0]  count;
        logic [7:0]  data;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic nonempty;
    } t_q_stat;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_WLO,
        ST_WHI,
        ST_ALO,
        ST_AHI,
        ST_RLO,
        ST_RHI,
        ST_MLO,
        ST_MHI,
        ST_PA,
        ST_PB,
        ST_PC
    } t_seq_state;

endpackage

// ----- rtl/i2cm_front.sv -----
// Front end: accepts input beats, decodes opcodes and normalises launch fields.
// Depends on i2cm_pkg; feeds i2cm_queue.
module i2cm_front (
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  i2cm_pkg::t_in_item i_in_data,
    input  i2cm_pkg::t_q_stat  i_q_stat,
    output logic              o_push,
    output i2cm_pkg::t_cmd     o_cmd
);
    import i2cm_pkg::*;

    // Handshake: hold off only while the queue is full
    assign o_in_stall = i_q_stat.full;
    assign o_push     = i_in_valid && !i_q_stat.full;

    // Classify the beat; opcode three counts as a tick
    always_comb begin
        unique case (i_in_data.opcode)
            OpLaunch: o_cmd.kind = CMD_LAUNCH;
            OpLoad:   o_cmd.kind = CMD_LOAD;
            default:  o_cmd.kind = CMD_TICK;
        endcase
        o_cmd.sda      = i_in_data.sda_in;
        o_cmd.addr     = i_in_data.target_addr;
        o_cmd.reg_addr = i_in_data.reg_addr;
        o_cmd.two_byte = (i_in_data.reg_addr_len == SubLenTwo);
        o_cmd.is_read  = i_in_data.is_read;
        o_cmd.count    = (i_in_data.byte_count > CountMax) ? CountMax
                                                           : i_in_data.byte_count;
        o_cmd.data     = i_in_data.data_byte;
    end

endmodule

// ----- rtl/i2cm_queue.sv -----
// Short command queue decoupling the front end from the sequencer.
// Depends on i2cm_pkg.
module i2cm_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  i2cm_pkg::t_cmd     i_cmd,
    input  logic              i_pop,
    output i2cm_pkg::t_cmd     o_cmd,
    output i2cm_pkg::t_q_stat  o_stat
);
    import i2cm_pkg::*;

    t_cmd             r_mem [QDepth];
    logic [QPtrW-1:0] r_wr_ptr;
    logic [QPtrW-1:0] r_rd_ptr;
    logic [QPtrW:0]   r_count;

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_cmd           = r_mem[r_rd_ptr];
    assign o_stat.full     = (r_count == (QPtrW + 1)'(QDepth));
    assign o_stat.nonempty = (r_count != '0);

endmodule

// ----- rtl/i2cm_back.sv -----
// Back end: pin sequencer, write buffer and result register.
// Depends on i2cm_pkg; pops commands from i2cm_queue.
module i2cm_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [15:0]        i_phase_ticks,
    input  i2cm_pkg::t_q_stat   i_q_stat,
    input  i2cm_pkg::t_cmd      i_cmd,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output i2cm_pkg::t_out_item o_out_data
);
    import i2cm_pkg::*;

    t_seq_state      r_state,     n_state;
    logic [2:0]      r_bit_idx,   n_bit_idx;
    logic [IdxW-1:0] r_byte_idx,  n_byte_idx;
    logic [7:0]      r_shift,     n_shift;
    logic [15:0]     r_phase_cnt, n_phase_cnt;
    logic [LpW-1:0]  r_load_ptr,  n_load_ptr;
    logic [6:0]      r_addr,      n_addr;
    logic [15:0]     r_reg,       n_reg;
    logic            r_two,       n_two;
    logic            r_read,      n_read;
    logic [4:0]      r_count,     n_count;
    logic            r_seg2,      n_seg2;
    logic            r_nack,      n_nack;
    logic [7:0]      r_wbuf [MaxBytes];
    logic            r_out_valid;
    t_out_item       r_out,       n_out;

    logic            w_step;
    logic            w_wr_en;
    logic [15:0]     w_len;
    logic            w_phase_end;
    logic [1:0]      w_sub_len;
    logic [IdxW-1:0] w_k;
    logic [IdxW-1:0] w_d;
    logic [5:0]      w_total;
    logic            w_more;
    logic [7:0]      w_seg1;
    logic [7:0]      w_rx;
    logic            w_rvalid;
    logic            w_done;
    logic            w_stat;

    // One command per cycle whenever the result register is free
    assign w_step = i_q_stat.nonempty && (!r_out_valid || !i_out_stall);
    assign o_pop  = w_step;

    // Phase timing; zero ticks per phase behaves as one
    assign w_len       = (i_phase_ticks == '0) ? 16'd1 : i_phase_ticks;
    assign w_phase_end = ({1'b0, r_phase_cnt} + 17'd1) >= {1'b0, w_len};

    // Next byte of the first segment: address, sub-address, buffered data
    always_comb begin
        w_sub_len = r_two ? 2'd2 : 2'd1;
        w_k       = r_byte_idx + 1'b1;
        w_d       = r_byte_idx - IdxW'(w_sub_len);
        w_total   = 6'd1 + 6'(w_sub_len) + (r_read ? 6'd0 : 6'(r_count));
        w_more    = {1'b0, w_k} < w_total;
        priority if (w_k <= IdxW'(w_sub_len)) begin
            w_seg1 = (r_two && w_k == IdxW'(1)) ? r_reg[15:8] : r_reg[7:0];
        end else if (w_d < IdxW'(MaxBytes)) begin
            w_seg1 = r_wbuf[w_d[PtrW-1:0]];
        end else begin
            w_seg1 = 8'h00;
        end
        w_rx = {r_shift[6:0], i_cmd.sda};
    end

    // Next-state logic
    always_comb begin
        n_state     = r_state;
        n_bit_idx   = r_bit_idx;
        n_byte_idx  = r_byte_idx;
        n_shift     = r_shift;
        n_phase_cnt = r_phase_cnt;
        n_load_ptr  = r_load_ptr;
        n_addr      = r_addr;
        n_reg       = r_reg;
        n_two       = r_two;
        n_read      = r_read;
        n_count     = r_count;
        n_seg2      = r_seg2;
        n_nack      = r_nack;
        w_wr_en     = 1'b0;
        w_rvalid    = 1'b0;
        w_done      = 1'b0;
        w_stat      = 1'b0;
        if (w_step) begin
            unique case (i_cmd.kind)
                CMD_LAUNCH: begin
                    if (r_state == ST_IDLE) begin
                        n_addr      = i_cmd.addr;
                        n_reg       = i_cmd.reg_addr;
                        n_two       = i_cmd.two_byte;
                        n_read      = i_cmd.is_read;
                        n_count     = i_cmd.count;
                        n_seg2      = 1'b0;
                        n_nack      = 1'b0;
                        n_load_ptr  = '0;
                        n_byte_idx  = '0;
                        n_bit_idx   = '0;
                        n_shift     = '0;
                        n_phase_cnt = '0;
                        n_state     = ST_START;
                    end
                end
                CMD_LOAD: begin
                    if (r_state == ST_IDLE && r_load_ptr < LpW'(MaxBytes)) begin
                        w_wr_en    = 1'b1;
                        n_load_ptr = r_load_ptr + 1'b1;
                    end
                end
                default: begin
                    if (r_state != ST_IDLE && !w_phase_end) begin
                        n_phase_cnt = r_phase_cnt + 16'd1;
                    end else if (r_state != ST_IDLE) begin
                        n_phase_cnt = '0;
                        unique case (r_state)
                            ST_START: begin
                                n_byte_idx = '0;
                                n_bit_idx  = '0;
                                n_state    = ST_WLO;
                                n_shift    = r_seg2 ? {r_addr, AddrReadBit}
                                                    : {r_addr, 1'b0};
                            end
                            ST_WLO: n_state = ST_WHI;
                            ST_WHI: begin
                                if (r_bit_idx == 3'd7) begin
                                    n_state = ST_ALO;
                                end else begin
                                    n_bit_idx = r_bit_idx + 3'd1;
                                    n_shift   = {r_shift[6:0], 1'b0};
                                    n_state   = ST_WLO;
                                end
                            end
                            ST_ALO: n_state = ST_AHI;
                            ST_AHI: begin
                                // target ACK slot: low means acknowledged
                                priority if (i_cmd.sda) begin
                                    n_nack  = 1'b1;
                                    n_state = ST_PA;
                                end else if (r_seg2) begin
                                    if (r_count == '0) begin
                                        n_state = ST_PA;
                                    end else begin
                                        n_byte_idx = '0;
                                        n_bit_idx  = '0;
                                        n_shift    = '0;
                                        n_state    = ST_RLO;
                                    end
                                end else begin
                                    n_byte_idx = w_k;
                                    if (w_more) begin
                                        n_shift   = w_seg1;
                                        n_bit_idx = '0;
                                        n_state   = ST_WLO;
                                    end else begin
                                        n_state = ST_PA;
                                    end
                                end
                            end
                            ST_RLO: n_state = ST_RHI;
                            ST_RHI: begin
                                n_shift = w_rx;
                                if (r_bit_idx == 3'd7) begin
                                    w_rvalid = 1'b1;
                                    n_state  = ST_MLO;
                                end else begin
                                    n_bit_idx = r_bit_idx + 3'd1;
                                    n_state   = ST_RLO;
                                end
                            end
                            ST_MLO: n_state = ST_MHI;
                            ST_MHI: begin
                                n_byte_idx = w_k;
                                if (w_k < r_count) begin
                                    n_bit_idx = '0;
                                    n_shift   = '0;
                                    n_state   = ST_RLO;
                                end else begin
                                    n_state = ST_PA;
                                end
                            end
                            ST_PA: n_state = ST_PB;
                            ST_PB: n_state = ST_PC;
                            ST_PC: begin
                                // a read without a NACK restarts for its second segment
                                if (r_read && !r_seg2 && !r_nack) begin
                                    n_seg2  = 1'b1;
                                    n_state = ST_START;
                                end else begin
                                    w_done  = 1'b1;
                                    w_stat  = r_nack;
                                    n_seg2  = 1'b0;
                                    n_nack  = 1'b0;
                                    n_state = ST_IDLE;
                                end
                            end
                            default: n_state = r_state;
                        endcase
                    end
                end
            endcase
        end
    end

    // Pin levels for the phase in force after this step
    always_comb begin
        n_out            = '0;
        n_out.scl_level  = 1'b1;
        n_out.sda_level  = 1'b1;
        n_out.sda_drive  = 1'b1;
        n_out.busy_res   = (n_state != ST_IDLE);
        n_out.read_valid = w_rvalid;
        n_out.read_data  = w_rvalid ? w_rx : 8'h00;
        n_out.done_res   = w_done;
        n_out.status     = w_stat;
        unique case (n_state)
            ST_START: n_out.sda_level = 1'b0;
            ST_WLO: begin
                n_out.scl_level = 1'b0;
                n_out.sda_level = n_shift[7];
            end
            ST_WHI:  n_out.sda_level = n_shift[7];
            ST_ALO, ST_RLO: begin
                n_out.scl_level = 1'b0;
                n_out.sda_drive = 1'b0;
            end
            ST_AHI, ST_RHI: n_out.sda_drive = 1'b0;
            ST_MLO, ST_MHI: begin
                // NACK on the last byte, ACK otherwise
                n_out.scl_level = (n_state == ST_MHI);
                n_out.sda_level = ({1'b0, n_byte_idx} + 6'd1) >= {1'b0, n_count};
            end
            ST_PA: begin
                n_out.scl_level = 1'b0;
                n_out.sda_level = 1'b0;
            end
            ST_PB:  n_out.sda_level = 1'b0;
            default: n_out.busy_res = (n_state != ST_IDLE);
        endcase
    end

    // Write buffer, loaded only while idle
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_wbuf[r_load_ptr[PtrW-1:0]] <= i_cmd.data;
        end
    end

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_bit_idx   <= '0;
            r_byte_idx  <= '0;
            r_shift     <= '0;
            r_phase_cnt <= '0;
            r_load_ptr  <= '0;
            r_addr      <= '0;
            r_reg       <= '0;
            r_two       <= 1'b0;
            r_read      <= 1'b0;
            r_count     <= '0;
            r_seg2      <= 1'b0;
            r_nack      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bit_idx   <= n_bit_idx;
            r_byte_idx  <= n_byte_idx;
            r_shift     <= n_shift;
            r_phase_cnt <= n_phase_cnt;
            r_load_ptr  <= n_load_ptr;
            r_addr      <= n_addr;
            r_reg       <= n_reg;
            r_two       <= n_two;
            r_read      <= n_read;
            r_count     <= n_count;
            r_seg2      <= n_seg2;
            r_nack      <= n_nack;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- rtl/i2c_master_register_transfer_top.sv -----
// A taken input beat is stored in the queue, and its result then in the result
// register, from which it leaves as a result beat.
// Throughput: one beat per cycle while neither side stalls; the two-entry queue
// lets input and output stall independently.
// Reset (synchronous, active low): idle, queue and result register empty,
// phase_ticks back to 2; no clearing pass is needed.
// Top level of the I2C register transfer master; depends on i2cm_pkg,
// i2cm_front, i2cm_queue and i2cm_back.
module i2c_master_register_transfer_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  i2cm_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output i2cm_pkg::t_out_item o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [15:0]        i_cfg_data
);
    import i2cm_pkg::*;

    logic [15:0] r_phase_ticks;
    logic        w_push;
    logic        w_pop;
    t_cmd        w_front_cmd;
    t_cmd        w_q_cmd;
    t_q_stat     w_q_stat;

    // Configuration register, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= PhaseTicksRst;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_phase_ticks <= i_cfg_data;
            end
        end
    end

    i2cm_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_q_stat   (w_q_stat),
        .o_push     (w_push),
        .o_cmd      (w_front_cmd)
    );

    i2cm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_q_cmd),
        .o_stat  (w_q_stat)
    );

    i2cm_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_phase_ticks (r_phase_ticks),
        .i_q_stat      (w_q_stat),
        .i_cmd         (w_q_cmd),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_data    (o_out_data)
    );

endmodule

// ----- rtl/i2cm_checker.sv -----
// Port-level checker for the I2C register transfer master, with its bind.
// Depends on i2cm_pkg and i2c_master_register_transfer_top_assert.svh.
`include "i2c_master_register_transfer_top_assert.svh"

module i2cm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_stall,
    input i2cm_pkg::t_out_item i_out_data
);
    import i2cm_pkg::*;

    // A stalled result beat holds
    `I2CM_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && i_out_stall, i_out_valid && $stable(i_out_data))

    // A received byte leaves the master driving the ACK bit with SCL low
    `I2CM_ASSERT_IMP(a_read_ack, i_clk, i_rst_n, i_out_valid && i_out_data.read_valid, !i_out_data.scl_level && i_out_data.sda_drive && i_out_data.busy_res)

    // Idle bus: both lines high and driven
    `I2CM_ASSERT_IMP(a_idle_bus, i_clk, i_rst_n, i_out_valid && !i_out_data.busy_res, i_out_data.scl_level && i_out_data.sda_level && i_out_data.sda_drive)

    // NACK status only on the completing beat
    `I2CM_ASSERT_IMP(a_status_done, i_clk, i_rst_n, i_out_valid && i_out_data.status, i_out_data.done_res && !i_out_data.busy_res)

endmodule

bind i2c_master_register_transfer_top i2cm_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);
